// File: rtl/core/ilb_pkg.sv
`default_nettype none

package ilb_pkg;

    localparam int unsigned CMD_W = 3;
    localparam int unsigned POS_W = 7;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CNT_OUT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_HEAD   = 3'd1,
        CMD_TAIL   = 3'd2,
        CMD_AT     = 3'd3,
        CMD_DELETE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_READ = 2'd1,
        KIND_INS  = 2'd2,
        KIND_DEL  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_READ   = 3'd1,
        S_SH_RD  = 3'd2,
        S_SH_WR  = 3'd3,
        S_INS_WR = 3'd4,
        S_DONE   = 3'd5
    } t_state;

    // datapath -> controller
    typedef struct packed {
        t_kind kind;   // decoded from the offered command, valid ops only
        logic  shift;  // entries must move for the offered command
        logic  up;     // latched: current walk belongs to an insert
        logic  last;   // latched walk index reached its stop
    } t_dp_status;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rv_load;
        logic sh_rd;
        logic sh_wr;
        logic ins_wr;
        logic cnt_dec;
    } t_dp_ctrl;

endpackage

`default_nettype wire

// File: rtl/core/indexed_list_buffer.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries, position 0 at the head.
// Command channel: present i_cmd, i_position, i_value with start high; the
// transfer happens at a rising edge with start high and busy low.
// Result channel: o_valid is high for exactly one cycle with o_read_value,
// o_status and o_entry_count; the receiver cannot stall, it must take it then.
// Entries live in a single-port memory; an insert or delete moves each later
// entry by one slot, each moved entry read in S_SH_RD and then written in S_SH_WR.
// Controller states from the transfer edge up to the o_valid cycle:
//   refused / unused command, delete of the last entry  : S_DONE
//   read                                                : S_READ, S_DONE
//   insert moving n entries  : S_SH_RD, S_SH_WR per entry, then S_INS_WR, S_DONE
//   delete moving n entries  : S_SH_RD, S_SH_WR per entry, then S_DONE
// busy drops the cycle after o_valid.
// Reset (i_rst_n low at a rising edge) empties the list and returns to idle;
// memory contents are not cleared, entries beyond the count are never read.
module indexed_list_buffer #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic        [ilb_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic        [ilb_pkg::POS_W-1:0]      i_position,
    input  wire logic signed [ilb_pkg::VAL_W-1:0]      i_value,
    output      logic                                  o_valid,
    output      logic signed [ilb_pkg::VAL_W-1:0]      o_read_value,
    output      logic        [1:0]                     o_status,
    output      logic        [ilb_pkg::CNT_OUT_W-1:0]  o_entry_count
);
    import ilb_pkg::*;

    t_dp_status dp_status;
    t_dp_ctrl   dp_ctrl;

    ilb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_dp_status (dp_status),
        .o_dp_ctrl   (dp_ctrl),
        .o_busy      (busy),
        .o_valid     (o_valid)
    );

    ilb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_ctrl     (dp_ctrl),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_dp_status   (dp_status),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not start work");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("still busy after result");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DONE)) |-> (o_read_value == '1))
        else $error("failed command returned a value");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside of work");

endmodule

`default_nettype wire

// File: rtl/core/ilb_ctrl.sv
`default_nettype none

module ilb_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire ilb_pkg::t_dp_status i_dp_status,
    output      ilb_pkg::t_dp_ctrl   o_dp_ctrl,
    output      logic                o_busy,
    output      logic                o_valid
);
    import ilb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_dp_status.kind)
                        KIND_READ: n_state = S_READ;
                        KIND_INS:  n_state = i_dp_status.shift ? S_SH_RD : S_INS_WR;
                        KIND_DEL:  n_state = i_dp_status.shift ? S_SH_RD : S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_READ:  n_state = S_DONE;
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: begin
                if (i_dp_status.last) begin
                    n_state = i_dp_status.up ? S_INS_WR : S_DONE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_INS_WR: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_ctrl         = '0;
        o_dp_ctrl.accept  = (r_state == S_IDLE) && i_start;
        o_dp_ctrl.rv_load = (r_state == S_READ);
        o_dp_ctrl.sh_rd   = (r_state == S_SH_RD);
        o_dp_ctrl.sh_wr   = (r_state == S_SH_WR);
        o_dp_ctrl.ins_wr  = (r_state == S_INS_WR);
        o_dp_ctrl.cnt_dec = ((r_state == S_IDLE) && i_start &&
                             (i_dp_status.kind == KIND_DEL) && !i_dp_status.shift) ||
                            ((r_state == S_SH_WR) && i_dp_status.last && !i_dp_status.up);
        o_busy            = (r_state != S_IDLE);
        o_valid           = (r_state == S_DONE);
    end

endmodule

`default_nettype wire

// File: rtl/core/ilb_dp.sv
`default_nettype none

module ilb_dp #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ilb_pkg::t_dp_ctrl                   i_dp_ctrl,
    input  wire logic        [ilb_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic        [ilb_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [ilb_pkg::VAL_W-1:0]    i_value,
    output      ilb_pkg::t_dp_status                 o_dp_status,
    output      logic signed [ilb_pkg::VAL_W-1:0]    o_read_value,
    output      logic        [1:0]                   o_status,
    output      logic        [ilb_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import ilb_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;

    logic signed [VAL_W-1:0] mem [CAPACITY];

    logic        [CW-1:0]    r_count;
    logic        [AW-1:0]    r_idx;
    logic        [AW-1:0]    r_stop;
    logic                    r_up;
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_rdata;
    logic signed [VAL_W-1:0] r_rv;
    t_status                 r_status;

    logic    [MW-1:0] pos_ext;
    logic    [MW-1:0] cnt_ext;
    logic    [MW-1:0] ipos;
    t_kind            kind;
    logic             shift;
    t_status          status;
    logic    [AW-1:0] idx_init;
    logic    [AW-1:0] stop_init;
    logic    [AW-1:0] waddr;
    logic signed [VAL_W-1:0] wdata;
    logic             wen;

    always_comb begin
        pos_ext   = MW'(i_position);
        cnt_ext   = MW'(r_count);
        ipos      = pos_ext;
        kind      = KIND_NONE;
        shift     = 1'b0;
        status    = ST_DONE;
        idx_init  = AW'(pos_ext);
        stop_init = AW'(pos_ext);
        case (i_cmd)
            CMD_READ: begin
                if (pos_ext < cnt_ext) begin
                    kind = KIND_READ;
                end else begin
                    status = ST_RANGE;
                end
            end
            CMD_HEAD, CMD_TAIL, CMD_AT: begin
                if (i_cmd == CMD_HEAD) begin
                    ipos = '0;
                end else if (i_cmd == CMD_TAIL) begin
                    ipos = cnt_ext;
                end
                if (ipos > cnt_ext) begin
                    status = ST_RANGE;
                end else if (cnt_ext >= MW'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    kind = KIND_INS;
                end
                shift     = (ipos < cnt_ext);
                idx_init  = AW'(cnt_ext - MW'(1));
                stop_init = AW'(ipos);
            end
            CMD_DELETE: begin
                if (pos_ext < cnt_ext) begin
                    kind = KIND_DEL;
                end else begin
                    status = ST_RANGE;
                end
                shift     = ((pos_ext + MW'(1)) != cnt_ext);
                idx_init  = AW'(pos_ext + MW'(1));
                stop_init = AW'(cnt_ext - MW'(1));
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
    end

    always_comb begin
        o_dp_status       = '0;
        o_dp_status.kind  = kind;
        o_dp_status.shift = shift;
        o_dp_status.up    = r_up;
        o_dp_status.last  = (r_idx == r_stop);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_up    <= 1'b0;
        end else begin
            if (i_dp_ctrl.accept) begin
                r_up <= (kind == KIND_INS);
            end
            if (i_dp_ctrl.ins_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_dp_ctrl.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // walk index and result
    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.accept) begin
            r_idx    <= idx_init;
            r_stop   <= stop_init;
            r_val    <= i_value;
            r_status <= status;
        end else if (i_dp_ctrl.sh_wr && (r_idx != r_stop)) begin
            r_idx <= r_up ? (r_idx - AW'(1)) : (r_idx + AW'(1));
        end
    end

    always_comb begin
        wen   = i_dp_ctrl.sh_wr || i_dp_ctrl.ins_wr;
        waddr = r_stop;
        wdata = r_val;
        if (i_dp_ctrl.sh_wr) begin
            waddr = r_up ? (r_idx + AW'(1)) : (r_idx - AW'(1));
            wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (i_dp_ctrl.sh_rd) begin
            r_rdata <= mem[r_idx];
        end
        if (i_dp_ctrl.accept) begin
            r_rv <= '1;
        end else if (i_dp_ctrl.rv_load) begin
            r_rv <= mem[r_idx];
        end
    end

    assign o_read_value  = r_rv;
    assign o_status      = r_status;
    assign o_entry_count = cnt_ext[CNT_OUT_W-1:0];

endmodule

`default_nettype wire

// File: test/ilb_list_checker.sv
`default_nettype none

module ilb_list_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    input  wire logic                                  busy,
    input  wire logic        [ilb_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic        [ilb_pkg::POS_W-1:0]      i_position,
    input  wire logic        [ilb_pkg::VAL_W-1:0]      i_value,
    input  wire logic                                  o_valid,
    input  wire logic        [ilb_pkg::VAL_W-1:0]      o_read_value,
    input  wire logic        [1:0]                     o_status,
    input  wire logic        [ilb_pkg::CNT_OUT_W-1:0]  o_entry_count,
    output int unsigned                                mismatches,
    output int unsigned                                replies_pending
);
    import ilb_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_list_reply;

    logic [VAL_W-1:0] stored [CAPACITY];
    int unsigned      held;
    t_list_reply      replies_due [$];
    t_list_reply      want;
    t_list_reply      got;

    function automatic t_status place_entry(int unsigned at, logic [VAL_W-1:0] val);
        if (at > held)
            return ST_RANGE;
        if (held >= CAPACITY)
            return ST_FULL;
        for (int unsigned i = held; i > at; i--)
            stored[i] = stored[i-1];
        stored[at] = val;
        held++;
        return ST_DONE;
    endfunction

    function automatic t_list_reply predict_reply(logic [CMD_W-1:0] op,
                                                  logic [POS_W-1:0] pos,
                                                  logic [VAL_W-1:0] val);
        t_list_reply r;
        r.read_value = '1;
        r.status     = ST_DONE;
        case (op)
            CMD_READ: begin
                if (pos < held)
                    r.read_value = stored[pos];
                else
                    r.status = ST_RANGE;
            end
            CMD_HEAD: r.status = place_entry(0, val);
            CMD_TAIL: r.status = place_entry(held, val);
            CMD_AT:   r.status = place_entry(pos, val);
            CMD_DELETE: begin
                if (pos < held) begin
                    for (int unsigned i = pos; i + 1 < held; i++)
                        stored[i] = stored[i+1];
                    held--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_OUT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            replies_due.delete();
        end else begin
            // result first: it always belongs to an older transfer
            if (o_valid) begin
                got = {o_read_value, o_status, o_entry_count};
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result: value %0d status %0d count %0d",
                             $time, $signed(got.read_value), got.status, got.entry_count);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, $signed(want.read_value), want.status,
                                 want.entry_count, $signed(got.read_value), got.status,
                                 got.entry_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                replies_due.push_back(predict_reply(i_cmd, i_position, i_value));
        end
        replies_pending = replies_due.size();
    end

endmodule

`default_nettype wire

// File: test/indexed_list_buffer_tb.sv
`default_nettype none

module indexed_list_buffer_tb;
    import ilb_pkg::*;

    localparam int unsigned LIST_DEPTH      = 64;
    localparam int unsigned ITEMS_PER_PHASE = 300;
    localparam int unsigned SETTLE_CYCLES   = 2 * LIST_DEPTH + 8;
    localparam longint unsigned RUN_LIMIT   = 64'd500_000 * 8;

    typedef enum logic [1:0] {
        TREND_GROW,
        TREND_DRAIN,
        TREND_CHURN
    } t_fill_trend;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic [CMD_W-1:0]     i_cmd      = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic [VAL_W-1:0]     i_value    = '0;
    logic                 busy;
    logic                 o_valid;
    logic [VAL_W-1:0]     o_read_value;
    logic [1:0]           o_status;
    logic [CNT_OUT_W-1:0] o_entry_count;
    int unsigned          mismatches;
    int unsigned          replies_pending;
    int unsigned          sender_idle_pct;
    int unsigned          list_len;

    indexed_list_buffer #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_read_value(o_read_value),
        .o_status(o_status),
        .o_entry_count(o_entry_count)
    );

    ilb_list_checker #(
        .CAPACITY(LIST_DEPTH)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_read_value(o_read_value),
        .o_status(o_status),
        .o_entry_count(o_entry_count),
        .mismatches(mismatches),
        .replies_pending(replies_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("** indexed_list_buffer: FAILED **");
        $finish;
    end

    // list_len steers positions toward the live range and picks the fill trend
    task automatic issue(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= op;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        case (op)
            CMD_HEAD, CMD_TAIL: if (list_len < LIST_DEPTH) list_len++;
            CMD_AT:     if (pos <= list_len && list_len < LIST_DEPTH) list_len++;
            CMD_DELETE: if (pos < list_len) list_len--;
            default: ;
        endcase
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        wait (replies_pending == 0);
        @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position(bit insert_like);
        int unsigned span = insert_like ? list_len + 1 : list_len;
        if (span == 0 || $urandom_range(99) < 12)
            return POS_W'($urandom_range(0, 127));
        case ($urandom_range(3))
            0:       return '0;
            1:       return POS_W'(span - 1);
            default: return POS_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item(input t_fill_trend trend);
        int unsigned      roll;
        int unsigned      ins_pct;
        int unsigned      del_pct;
        logic [CMD_W-1:0] op;
        roll = $urandom_range(99);
        case (trend)
            TREND_GROW:  begin ins_pct = 72; del_pct = 10; end
            TREND_DRAIN: begin ins_pct = 15; del_pct = 62; end
            default:     begin ins_pct = 40; del_pct = 35; end
        endcase
        if (roll < ins_pct) begin
            case ($urandom_range(2))
                0:       op = CMD_HEAD;
                1:       op = CMD_TAIL;
                default: op = CMD_AT;
            endcase
            issue(op, pick_position(1'b1), pick_value());
        end else if (roll < ins_pct + del_pct) begin
            issue(CMD_DELETE, pick_position(1'b0), pick_value());
        end else if (roll < 97) begin
            issue(CMD_READ, pick_position(1'b0), pick_value());
        end else begin
            op = CMD_DELETE + CMD_W'($urandom_range(1, 3));
            issue(op, pick_position(1'b0), pick_value());
        end
    endtask

    task automatic random_phase(input int unsigned items);
        t_fill_trend trend   = TREND_GROW;
        int unsigned run_len = 90;
        for (int unsigned n = 0; n < items; n++) begin
            if (run_len == 0) begin
                if (list_len == LIST_DEPTH)
                    trend = TREND_DRAIN;
                else if (list_len == 0)
                    trend = TREND_GROW;
                else
                    trend = t_fill_trend'($urandom_range(2));
                run_len = $urandom_range(30, 90);
            end
            run_len--;
            random_item(trend);
        end
    endtask

    initial begin
        list_len        = 0;
        sender_idle_pct = 37;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: positional commands are out of range until the first inserts
        issue(CMD_READ, '0, $urandom);
        issue(CMD_DELETE, '0, $urandom);
        issue(CMD_AT, POS_W'(1), $urandom);
        issue(CMD_AT, '1, $urandom);
        issue(CMD_HEAD, '0, 32'h7FFF_FFFF);
        issue(CMD_TAIL, '1, 32'h8000_0000);
        issue(CMD_AT, POS_W'(1), '1);
        issue(CMD_AT, POS_W'(3), '0);
        for (int unsigned p = 0; p < 5; p++)
            issue(CMD_READ, POS_W'(p), $urandom);
        issue(CMD_READ, '1, $urandom);
        issue(CMD_DELETE, POS_W'(3), $urandom);
        issue(CMD_DELETE, '0, $urandom);
        issue(CMD_DELETE, '1, $urandom);
        for (int unsigned k = 1; k <= 3; k++)
            issue(CMD_DELETE + CMD_W'(k), POS_W'($urandom), $urandom);
        issue(CMD_HEAD, '1, 32'h5555_5555);
        issue(CMD_READ, '0, $urandom);
        hold_until_drained();

        random_phase(ITEMS_PER_PHASE);
        hold_until_drained();
        sender_idle_pct = 82;
        random_phase(ITEMS_PER_PHASE);
        hold_until_drained();
        sender_idle_pct = 0;
        random_phase(ITEMS_PER_PHASE);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("** indexed_list_buffer: PASSED **");
        else
            $display("** indexed_list_buffer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
